FILE: rtl/bbp_pkg.sv
// Shared types, constants and helper functions of the bitmap bit packer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package bbp_pkg;

  localparam int WordIdxW = 20;  // bits of a bitmap word index
  localparam int CfgW     = 26;  // bits of the start bit position
  localparam int LenW     = 11;  // bits of a request length
  localparam int DataW    = 64;  // bits of a bitmap word
  localparam int OffW     = 6;   // bits of a position inside a word
  localparam int CntW     = 7;   // bits of a count from 0 to 64
  localparam int QDepth   = 4;   // entries of the command queue
  localparam int QPtrW    = 2;   // queue pointer bits
  localparam int QCntW    = 3;   // queue fill count bits

  // Request type codes on the input port.
  localparam logic [1:0] REQ_RUN   = 2'd0;
  localparam logic [1:0] REQ_CHUNK = 2'd1;
  localparam logic [1:0] REQ_SKIP  = 2'd2;
  localparam logic [1:0] REQ_FLUSH = 2'd3;

  localparam logic [CntW-1:0] WordBits = CntW'(DataW);

  // Operations as the back end sees them after classification.
  typedef enum logic [1:0] {
    OP_RUN1  = 2'd0,
    OP_CHUNK = 2'd1,
    OP_SKIP  = 2'd2,
    OP_FLUSH = 2'd3
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [LenW-1:0]  len;
    logic [DataW-1:0] data;
  } cmd_t;

  // Mask of the n low bits, n from 0 to 64.
  function automatic logic [DataW-1:0] low_mask(input logic [CntW-1:0] n);
    logic [DataW-1:0] m;
    if (n >= WordBits) begin
      m = '1;
    end else begin
      m = (DataW'(1) << n) - DataW'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bbp_front.sv
// Front end: accepts requests and turns them into queue commands.
// Depends on bbp_pkg; feeds bbp_queue.
`default_nettype none

module bbp_front (
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [1:0]             req_type_i,
  input  wire logic                   bit_value_i,
  input  wire logic [bbp_pkg::LenW-1:0] length_i,
  input  wire logic [bbp_pkg::DataW-1:0] chunk_data_i,
  input  wire logic                   q_full_i,
  output logic                        push_o,
  output bbp_pkg::cmd_t               cmd_o
);
  import bbp_pkg::*;

  localparam logic [LenW-1:0] ChunkMax = LenW'(DataW);

  logic accept;
  logic no_effect;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    cmd_o.data = chunk_data_i;
    cmd_o.len  = length_i;
    cmd_o.op   = OP_SKIP;
    no_effect  = (length_i == '0);
    case (req_type_i)
      REQ_RUN: begin
        // A run of zeros only moves the cursor, exactly like a skip.
        cmd_o.op = bit_value_i ? OP_RUN1 : OP_SKIP;
      end
      REQ_CHUNK: begin
        cmd_o.op = OP_CHUNK;
        if (length_i > ChunkMax) begin
          cmd_o.len = ChunkMax;
        end
      end
      REQ_SKIP: begin
        cmd_o.op = OP_SKIP;
      end
      REQ_FLUSH: begin
        cmd_o.op  = OP_FLUSH;
        no_effect = 1'b0;
      end
      default: begin
        cmd_o.op = OP_SKIP;
      end
    endcase
  end

  // Zero-length requests other than a flush change nothing and are dropped after the transfer.
  assign push_o = accept && !no_effect;

endmodule

`default_nettype wire

FILE: rtl/bbp_queue.sv
// Short command queue between the front end and the back end.
// Depends on bbp_pkg for the command type and the depth.
`default_nettype none

module bbp_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bbp_pkg::cmd_t  cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output bbp_pkg::cmd_t       cmd_o
);
  import bbp_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

endmodule

`default_nettype wire

FILE: rtl/bbp_back.sv
// Back end: holds the cursor and the partial word, executes one command at
// a time and drives the output register. Depends on bbp_pkg.
`default_nettype none

module bbp_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [bbp_pkg::CfgW-1:0]   cfg_wdata_i,
  input  wire logic                       q_valid_i,
  input  wire bbp_pkg::cmd_t              q_cmd_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [bbp_pkg::WordIdxW-1:0]    word_index_o,
  output logic [bbp_pkg::DataW-1:0]       word_data_o,
  output logic                            last_o
);
  import bbp_pkg::*;

  // Cursor and word being built.
  logic [WordIdxW-1:0] word_q, word_d;
  logic [OffW-1:0]     off_q, off_d;
  logic [DataW-1:0]    part_q, part_d;

  // Command in execution.
  logic                cur_valid_q, cur_valid_d;
  op_e                 cur_op_q;
  logic [LenW-1:0]     left_q, left_d;
  logic [DataW-1:0]    data_q;

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic [WordIdxW-1:0] oidx_q, oidx_d;
  logic [DataW-1:0]    odata_q, odata_d;
  logic                olast_q, olast_d;

  logic                out_free;
  logic                exec;

  // Run of ones.
  logic [CntW-1:0]     room;
  logic                run_cross;
  logic [CntW-1:0]     run_take;
  logic [LenW-1:0]     run_rest;
  logic [DataW-1:0]    run_word;

  // Chunk.
  logic [CntW-1:0]     chk_cnt;
  logic [DataW-1:0]    chk_bits;
  logic [DataW-1:0]    chk_word;
  logic [CntW-1:0]     chk_pos;
  logic [DataW-1:0]    chk_carry;

  // Skip.
  logic [LenW:0]       skp_pos;
  logic                skp_cross;

  assign out_free = !out_valid_q || !out_stall_i;
  assign exec     = cur_valid_q && out_free;
  assign pop_o    = q_valid_i && !cur_valid_q;

  always_comb begin
    room      = WordBits - CntW'(off_q);
    run_cross = (left_q >= LenW'(room));
    run_take  = run_cross ? room : left_q[CntW-1:0];
    run_rest  = left_q - LenW'(run_take);
    run_word  = part_q | (low_mask(run_take) << off_q);

    chk_cnt   = left_q[CntW-1:0];
    chk_bits  = data_q & low_mask(chk_cnt);
    chk_word  = part_q | (chk_bits << off_q);
    chk_pos   = CntW'(off_q) + chk_cnt;
    // Bits of the chunk that spill into the next word.
    chk_carry = (off_q == '0) ? '0 : (chk_bits >> room);

    skp_pos   = (LenW + 1)'(off_q) + (LenW + 1)'(left_q);
    skp_cross = (skp_pos[LenW:OffW] != '0);
  end

  always_comb begin
    word_d      = word_q;
    off_d       = off_q;
    part_d      = part_q;
    cur_valid_d = cur_valid_q;
    left_d      = left_q;
    out_valid_d = out_valid_q;
    oidx_d      = oidx_q;
    odata_d     = odata_q;
    olast_d     = olast_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (pop_o) begin
      cur_valid_d = 1'b1;
      left_d      = q_cmd_i.len;
    end

    if (exec) begin
      cur_valid_d = 1'b0;
      oidx_d      = word_q;
      olast_d     = 1'b1;
      case (cur_op_q)
        OP_FLUSH: begin
          out_valid_d = 1'b1;
          odata_d     = part_q;
        end
        OP_SKIP: begin
          off_d = skp_pos[OffW-1:0];
          if (skp_cross) begin
            out_valid_d = (part_q != '0);
            odata_d     = part_q;
            part_d      = '0;
            word_d      = word_q + WordIdxW'(skp_pos[LenW:OffW]);
          end
        end
        OP_CHUNK: begin
          off_d = chk_pos[OffW-1:0];
          if (chk_pos[CntW-1]) begin
            out_valid_d = (chk_word != '0);
            odata_d     = chk_word;
            part_d      = chk_carry;
            word_d      = word_q + WordIdxW'(1);
          end else begin
            part_d = chk_word;
          end
        end
        OP_RUN1: begin
          if (run_cross) begin
            // Each word the run fills is nonzero and goes out.
            out_valid_d = 1'b1;
            odata_d     = run_word;
            word_d      = word_q + WordIdxW'(1);
            if (run_rest < LenW'(DataW)) begin
              olast_d = 1'b1;
              part_d  = low_mask(run_rest[CntW-1:0]);
              off_d   = run_rest[OffW-1:0];
            end else begin
              olast_d     = 1'b0;
              part_d      = '0;
              off_d       = '0;
              left_d      = run_rest;
              cur_valid_d = 1'b1;
            end
          end else begin
            part_d = run_word;
            off_d  = off_q + run_take[OffW-1:0];
          end
        end
        default: begin
          cur_valid_d = 1'b0;
        end
      endcase
    end

    if (cfg_we_i) begin
      word_d = WordIdxW'(cfg_wdata_i[CfgW-1:OffW]);
      off_d  = cfg_wdata_i[OffW-1:0];
      part_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q      <= '0;
      off_q       <= '0;
      part_q      <= '0;
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      word_q      <= word_d;
      off_q       <= off_d;
      part_q      <= part_d;
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_op_q <= q_cmd_i.op;
      data_q   <= q_cmd_i.data;
    end
    left_q  <= left_d;
    oidx_q  <= oidx_d;
    odata_q <= odata_d;
    olast_q <= olast_d;
  end

  assign out_valid_o  = out_valid_q;
  assign word_index_o = oidx_q;
  assign word_data_o  = odata_q;
  assign last_o       = olast_q;

  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && (cur_op_q == OP_RUN1 || cur_op_q == OP_SKIP)) |-> (left_q != '0))
    else $error("run or skip in execution with zero length");

  a_chunk_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && cur_op_q == OP_CHUNK) |->
      (left_q != '0 && left_q <= LenW'(DataW)))
    else $error("chunk count out of range");

  a_run_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && cur_op_q == OP_RUN1 && run_cross) |=> (out_valid_q && odata_q != '0))
    else $error("run step left a word without a nonzero transfer");

endmodule

`default_nettype wire

FILE: rtl/bitmap_bit_packer.sv
// A request passes through the queue, the back end's command register and the output
// register before its result leaves. The back end pops a command only once the last one
// has executed, as it has a single command register; a run of ones emits one word per
// cycle while it holds the back end and the output is not stalled. Reset puts the cursor
// at bit 0, clears the partial word and empties the queue; there is no clearing pass.
// Top level: ties the front end, the command queue and the back end. Uses bbp_pkg.
`default_nettype none

module bitmap_bit_packer (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [bbp_pkg::CfgW-1:0]   cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [1:0]                 req_type_i,
  input  wire logic                       bit_value_i,
  input  wire logic [bbp_pkg::LenW-1:0]   length_i,
  input  wire logic [bbp_pkg::DataW-1:0]  chunk_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [bbp_pkg::WordIdxW-1:0]    word_index_o,
  output logic [bbp_pkg::DataW-1:0]       word_data_o,
  output logic                            last_o
);
  import bbp_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  cmd_t push_cmd;
  cmd_t head_cmd;

  bbp_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .bit_value_i  (bit_value_i),
    .length_i     (length_i),
    .chunk_data_i (chunk_data_i),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .cmd_o        (push_cmd)
  );

  bbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  bbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_valid_i    (q_valid),
    .q_cmd_i      (head_cmd),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .word_index_o (word_index_o),
    .word_data_o  (word_data_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire
